### sv/tctr_pkg.sv
// Shared constants and types for the tile column to row transposer.
package tctr_pkg;

  localparam int MAX_ROW_BYTES = 64;
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] ROW_BYTES_RESET = 7'd50;

  localparam int NUM_BANKS = 8;
  localparam int BANK_SEL_W = 3;
  localparam logic [2:0] LAST_ROW = 3'd7;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_PUSH_FULL = 2'd1;
  localparam logic [1:0] STATUS_PULL_EMPTY = 2'd2;

  // Word held between the bank read and the output register.
  typedef struct packed {
    logic       valid;
    logic       data_valid;
    logic       row_last;
    logic       band_last;
    logic [1:0] status;
    logic [2:0] row;
  } stage_t;

endpackage

### sv/tctr_bank_ram.sv
// One byte-wide bank of the band store, with a registered read port.
module tctr_bank_ram #(
  parameter int Depth = tctr_pkg::MAX_ROW_BYTES,
  parameter int AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/tctr_ctrl.sv
// Band bookkeeping: load and emit counters, store addressing and first pipeline stage.
module tctr_ctrl #(
  parameter int MaxRowBytes = tctr_pkg::MAX_ROW_BYTES,
  parameter int IdxW = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tctr_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_op_i,
  input  logic [7:0]                   in_byte_i,
  input  logic                         advance_i,
  output logic [tctr_pkg::NUM_BANKS-1:0] wr_en_o,
  output logic [IdxW-1:0]              wr_addr_o,
  output logic [7:0]                   wr_data_o,
  output logic [IdxW-1:0]              rd_addr_o,
  output tctr_pkg::stage_t             stage_o
);

  localparam int AddrW = IdxW + tctr_pkg::BANK_SEL_W;
  localparam int RbW = ($clog2(MaxRowBytes + 1) > tctr_pkg::CFG_W) ?
                       $clog2(MaxRowBytes + 1) : tctr_pkg::CFG_W;
  localparam int CmpW = RbW + tctr_pkg::BANK_SEL_W;

  logic [tctr_pkg::CFG_W-1:0] row_bytes_q;
  logic [AddrW-1:0] load_count_q, load_count_d;
  logic             band_full_q, band_full_d;
  logic [2:0]       emit_row_q, emit_row_d;
  logic [IdxW-1:0]  emit_index_q, emit_index_d;
  tctr_pkg::stage_t stage_q, stage_d;

  logic [RbW-1:0]  rb_raw, rb_eff;
  logic [CmpW-1:0] band_size, load_next, index_next;
  logic            accept, push_ok;

  assign accept = in_valid_i && advance_i;

  always_comb begin
    rb_raw = RbW'(row_bytes_q);
    if (rb_raw == '0) begin
      rb_eff = RbW'(1);
    end else if (rb_raw > RbW'(MaxRowBytes)) begin
      rb_eff = RbW'(MaxRowBytes);
    end else begin
      rb_eff = rb_raw;
    end
  end

  assign band_size  = {rb_eff, 3'b000};
  assign load_next  = CmpW'(load_count_q) + CmpW'(1);
  assign index_next = CmpW'(emit_index_q) + CmpW'(1);
  assign push_ok    = accept && (in_op_i == tctr_pkg::OP_PUSH) && !band_full_q;

  always_comb begin
    load_count_d = load_count_q;
    band_full_d  = band_full_q;
    emit_row_d   = emit_row_q;
    emit_index_d = emit_index_q;

    stage_d            = stage_q;
    stage_d.valid      = stage_q.valid;

    if (advance_i) begin
      stage_d.valid      = in_valid_i;
      stage_d.data_valid = 1'b0;
      stage_d.row_last   = 1'b0;
      stage_d.band_last  = 1'b0;
      stage_d.status     = tctr_pkg::STATUS_OK;
      stage_d.row        = emit_row_q;
    end

    if (accept) begin
      if (in_op_i == tctr_pkg::OP_PUSH) begin
        if (band_full_q) begin
          stage_d.status = tctr_pkg::STATUS_PUSH_FULL;
        end else if (load_next >= band_size) begin
          band_full_d  = 1'b1;
          load_count_d = '0;
          emit_row_d   = '0;
          emit_index_d = '0;
        end else begin
          load_count_d = load_next[AddrW-1:0];
        end
      end else begin
        if (!band_full_q) begin
          stage_d.status = tctr_pkg::STATUS_PULL_EMPTY;
        end else begin
          stage_d.data_valid = 1'b1;
          if (index_next >= CmpW'(rb_eff)) begin
            stage_d.row_last = 1'b1;
            emit_index_d     = '0;
            if (emit_row_q == tctr_pkg::LAST_ROW) begin
              stage_d.band_last = 1'b1;
              band_full_d       = 1'b0;
              emit_row_d        = '0;
            end else begin
              emit_row_d = emit_row_q + 3'd1;
            end
          end else begin
            emit_index_d = index_next[IdxW-1:0];
          end
        end
      end
    end
  end

  // The low bits of the load position pick the bank, the rest the row within it.
  always_comb begin
    wr_en_o = '0;
    wr_en_o[load_count_q[tctr_pkg::BANK_SEL_W-1:0]] = push_ok;
  end

  assign wr_addr_o = load_count_q[AddrW-1:tctr_pkg::BANK_SEL_W];
  assign wr_data_o = in_byte_i;
  assign rd_addr_o = emit_index_q;
  assign stage_o   = stage_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q  <= tctr_pkg::ROW_BYTES_RESET;
      load_count_q <= '0;
      band_full_q  <= 1'b0;
      emit_row_q   <= '0;
      emit_index_q <= '0;
      stage_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        row_bytes_q <= cfg_wdata_i;
      end
      load_count_q <= load_count_d;
      band_full_q  <= band_full_d;
      emit_row_q   <= emit_row_d;
      emit_index_q <= emit_index_d;
      stage_q      <= stage_d;
    end
  end

endmodule

### sv/tctr_out_stage.sv
// Gathers one row byte from the eight bank outputs and holds it in the output register.
module tctr_out_stage (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tctr_pkg::stage_t                   stage_i,
  input  logic [tctr_pkg::NUM_BANKS-1:0][7:0] bank_data_i,
  input  logic                               out_ready_i,
  output logic                               advance_o,
  output logic                               out_valid_o,
  output logic [7:0]                         row_byte_o,
  output logic                               data_valid_o,
  output logic                               row_last_o,
  output logic                               band_last_o,
  output logic [1:0]                         status_o
);

  logic       out_valid_q;
  logic [7:0] row_byte_q, row_byte_d;
  logic       data_valid_q, row_last_q, band_last_q;
  logic [1:0] status_q;
  logic       take;

  assign take      = stage_i.valid && (!out_valid_q || out_ready_i);
  assign advance_o = !stage_i.valid || take;

  // Bank k holds the k-th pixel from the left, which lands in bit 7-k.
  always_comb begin
    row_byte_d = '0;
    for (int k = 0; k < tctr_pkg::NUM_BANKS; k++) begin
      row_byte_d[7-k] = bank_data_i[k][stage_i.row];
    end
    if (!stage_i.data_valid) begin
      row_byte_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      row_byte_q   <= row_byte_d;
      data_valid_q <= stage_i.data_valid;
      row_last_q   <= stage_i.row_last;
      band_last_q  <= stage_i.band_last;
      status_q     <= stage_i.status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_byte_o   = row_byte_q;
  assign data_valid_o = data_valid_q;
  assign row_last_o   = row_last_q;
  assign band_last_o  = band_last_q;
  assign status_o     = status_q;

endmodule

### sv/tile_column_to_row_transposer.sv
// Top level of the tile column to row transposer: control, eight store banks, output stage.
//
//   channel   direction  tdata                                  tuser       tlast
//   s_axis    in         [7:0] column_byte                      operation   -
//   m_axis    out        [7:0] row_byte, [8] data_valid,        row_last    band_last
//                        [10:9] status
//   cfg       in         cfg_wdata_i = row_bytes, cfg_we_i strobe
//
// One word is accepted per cycle while s_axis_tready is high; each result passes through
// the registered read of the eight store banks and then the output register.
// Reset clears the counters and the band-full flag; the store itself is not cleared.
// When m_axis stalls, the bank read and output registers hold and s_axis_tready
// drops only once both are occupied.
module tile_column_to_row_transposer #(
  parameter int MaxRowBytes = tctr_pkg::MAX_ROW_BYTES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tctr_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [7:0] column_byte
  input  logic                       s_axis_tuser,  // [0] operation
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [15:0]                m_axis_tdata,  // [7:0] row_byte, [8] data_valid,
                                                    // [10:9] status
  output logic                       m_axis_tuser,  // [0] row_last
  output logic                       m_axis_tlast
);

  localparam int IdxW = (MaxRowBytes > 1) ? $clog2(MaxRowBytes) : 1;

  logic [tctr_pkg::NUM_BANKS-1:0]      wr_en;
  logic [IdxW-1:0]                     wr_addr, rd_addr;
  logic [7:0]                          wr_data;
  logic [tctr_pkg::NUM_BANKS-1:0][7:0] bank_data;
  tctr_pkg::stage_t                    stage;
  logic                                advance;
  logic [7:0]                          row_byte;
  logic                                data_valid;
  logic [1:0]                          status;

  tctr_ctrl #(
    .MaxRowBytes(MaxRowBytes),
    .IdxW       (IdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .advance_i  (advance),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_addr_o  (rd_addr),
    .stage_o    (stage)
  );

  for (genvar b = 0; b < tctr_pkg::NUM_BANKS; b++) begin : g_bank
    tctr_bank_ram #(
      .Depth(MaxRowBytes),
      .AddrW(IdxW)
    ) u_bank (
      .clk_i  (clk_i),
      .we_i   (wr_en[b]),
      .waddr_i(wr_addr),
      .wdata_i(wr_data),
      .re_i   (advance),
      .raddr_i(rd_addr),
      .rdata_o(bank_data[b])
    );
  end

  tctr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .bank_data_i (bank_data),
    .out_ready_i (m_axis_tready),
    .advance_o   (advance),
    .out_valid_o (m_axis_tvalid),
    .row_byte_o  (row_byte),
    .data_valid_o(data_valid),
    .row_last_o  (m_axis_tuser),
    .band_last_o (m_axis_tlast),
    .status_o    (status)
  );

  assign s_axis_tready = advance;
  assign m_axis_tdata  = {5'b00000, status, data_valid, row_byte};

endmodule

### tb/tctr_transpose_checker.sv
// Checker for the tile column to row transposer: predicts every result word and compares it.
`timescale 1ns / 1ps

module tctr_transpose_checker
  import tctr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,
  input  logic             s_axis_tuser,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [15:0]      m_axis_tdata,
  input  logic             m_axis_tuser,
  input  logic             m_axis_tlast,
  output int               pending_o,
  output int               mismatches_o,
  output logic             band_full_o,
  output int               fill_level_o,
  output int               written_top_o,
  output int               band_size_o
);

  typedef struct packed {
    logic [7:0] row_byte;
    logic       data_valid;
    logic       row_last;
    logic       band_last;
    logic [1:0] status;
  } row_word_t;

  logic [7:0]       band_mem [MAX_ROW_BYTES*8];
  int               fill_count;
  logic             band_loaded;
  logic [2:0]       drain_row;
  int               drain_col;
  logic [CFG_W-1:0] width_reg;
  int               written_top = 0;
  int               mismatch_count = 0;
  row_word_t        expected_rows[$];

  function automatic int active_width();
    if (width_reg == '0) begin
      return 1;
    end
    if (int'(width_reg) > MAX_ROW_BYTES) begin
      return MAX_ROW_BYTES;
    end
    return int'(width_reg);
  endfunction

  function automatic row_word_t transpose_step(logic op, logic [7:0] column_byte);
    int        width;
    row_word_t res;
    width = active_width();
    res = '0;
    res.status = STATUS_OK;
    if (op == OP_PUSH) begin
      if (band_loaded) begin
        res.status = STATUS_PUSH_FULL;
      end else begin
        band_mem[fill_count] = column_byte;
        fill_count++;
        if (fill_count > written_top) begin
          written_top = fill_count;
        end
        // A narrowed width can leave the load count past the band size already.
        if (fill_count >= width * 8) begin
          band_loaded = 1'b1;
          fill_count = 0;
          drain_row = '0;
          drain_col = 0;
        end
      end
    end else if (!band_loaded) begin
      res.status = STATUS_PULL_EMPTY;
    end else begin
      // The leftmost pixel comes from the first of the eight column bytes.
      for (int k = 0; k < 8; k++) begin
        res.row_byte[7-k] = band_mem[drain_col*8 + k][drain_row];
      end
      res.data_valid = 1'b1;
      if (drain_col + 1 >= width) begin
        res.row_last = 1'b1;
        if (drain_row == LAST_ROW) begin
          res.band_last = 1'b1;
          band_loaded = 1'b0;
          drain_row = '0;
        end else begin
          drain_row++;
        end
        drain_col = 0;
      end else begin
        drain_col++;
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    row_word_t want;
    if (!rst_ni) begin
      fill_count = 0;
      band_loaded = 1'b0;
      drain_row = '0;
      drain_col = 0;
      width_reg = ROW_BYTES_RESET;
      expected_rows.delete();
    end else begin
      if (cfg_we_i) begin
        width_reg = cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_rows.size() == 0) begin
          $display("%0t: result word with none expected, expected nothing, actual %h",
                   $time, {m_axis_tlast, m_axis_tuser, m_axis_tdata});
          mismatch_count++;
        end else begin
          want = expected_rows.pop_front();
          check_field("row_byte", want.row_byte, m_axis_tdata[7:0]);
          check_field("data_valid", 8'(want.data_valid), 8'(m_axis_tdata[8]));
          check_field("status", 8'(want.status), 8'(m_axis_tdata[10:9]));
          check_field("row_last", 8'(want.row_last), 8'(m_axis_tuser));
          check_field("band_last", 8'(want.band_last), 8'(m_axis_tlast));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_rows.push_back(transpose_step(s_axis_tuser, s_axis_tdata));
      end
    end
    pending_o     <= expected_rows.size();
    mismatches_o  <= mismatch_count;
    band_full_o   <= band_loaded;
    fill_level_o  <= fill_count;
    written_top_o <= written_top;
    band_size_o   <= active_width() * 8;
  end

endmodule

### tb/tile_column_to_row_transposer_test.sv
// Testbench top for the tile column to row transposer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tile_column_to_row_transposer_test;
  import tctr_pkg::*;

  localparam int WORD_BUDGET = 650;
  localparam int STUCK_LIMIT = 2000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [15:0]      m_axis_tdata;
  logic             m_axis_tuser;
  logic             m_axis_tlast;

  int   pending;
  int   mismatches;
  logic band_full;
  int   fill_level;
  int   written_top;
  int   band_size;

  int words_sent = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int idle_cycles = 0;

  logic [7:0]       corner_bytes [8] = '{8'h00, 8'hFF, 8'h01, 8'h80,
                                         8'hAA, 8'h55, 8'h0F, 8'hF0};
  logic [CFG_W-1:0] width_plan [7] = '{7'd0, 7'd127, 7'd3, 7'd65, 7'd2, 7'd64, 7'd1};

  tile_column_to_row_transposer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  tctr_transpose_checker row_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .pending_o     (pending),
    .mismatches_o  (mismatches),
    .band_full_o   (band_full),
    .fill_level_o  (fill_level),
    .written_top_o (written_top),
    .band_size_o   (band_size)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver stalls, short and long, with a recurring window in which no new stall starts.
  always @(posedge clk_i) begin : sink_stalls
    int roll;
    cycle_count <= cycle_count + 1;
    roll = $urandom_range(0, 99);
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (cycle_count % 1024 >= 768) begin
      m_axis_tready <= 1'b1;
    end else if (roll < 12) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else if (roll < 14) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(10, 30);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CFG_W-1:0] random_width();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      return CFG_W'($urandom_range(1, 4));
    end
    if (roll < 90) begin
      return CFG_W'($urandom_range(5, 12));
    end
    return CFG_W'($urandom_range(0, 127));
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_word(input logic op, input logic [7:0] data, input bit gapless);
    int gap;
    gap = gapless ? 0 : pick_gap();
    if (!gapless && $urandom_range(0, 99) == 0) begin
      s_axis_tvalid <= 1'b0;
      wait_drained();
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  // One band: load it, then read it out, with refused words mixed in as noise.
  // Some loads and some read-outs stop early so that the next width lands mid-band.
  task automatic run_band_phase(input logic [CFG_W-1:0] width_val);
    int pushes;
    int pulls;
    bit gapless;
    bit loaded;
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (3) @(posedge clk_i);
    // A full band may only be narrowed onto bytes that have been written.
    if (band_full && int'(width_val) * 8 > written_top) begin
      width_val = CFG_W'($urandom_range(1, written_top / 8));
    end
    write_width(width_val);
    gapless = ($urandom_range(0, 3) == 0);
    loaded = band_full;
    if (!loaded) begin
      pushes = (fill_level < band_size) ? band_size - fill_level : 1;
      if (pushes > 1 && band_size > 128) begin
        pushes = $urandom_range(1, (pushes > 160) ? 160 : pushes - 1);
      end else if (pushes > 1 && $urandom_range(0, 5) == 0) begin
        pushes = $urandom_range(1, pushes - 1);
      end else begin
        loaded = 1'b1;
      end
      repeat (pushes) begin
        if ($urandom_range(0, 11) == 0) begin
          send_word(OP_PULL, 8'($urandom_range(0, 255)), gapless);
        end
        send_word(OP_PUSH, 8'($urandom_range(0, 255)), gapless);
      end
    end
    if (loaded) begin
      pulls = band_size;
      if ($urandom_range(0, 3) == 0) begin
        pulls = $urandom_range(1, pulls);
      end
      repeat (pulls) begin
        if ($urandom_range(0, 11) == 0) begin
          send_word(OP_PUSH, 8'($urandom_range(0, 255)), gapless);
        end
        send_word(OP_PULL, 8'($urandom_range(0, 255)), gapless);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pull from an empty band at the reset width, then one band one byte wide.
    send_word(OP_PULL, 8'hFF, 1'b1);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    write_width(CFG_W'(1));
    foreach (corner_bytes[i]) begin
      send_word(OP_PUSH, corner_bytes[i], 1'b1);
    end
    send_word(OP_PUSH, 8'hFF, 1'b1);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (8) send_word(OP_PULL, 8'h00, 1'b0);
    send_word(OP_PULL, 8'h00, 1'b0);

    foreach (width_plan[i]) begin
      run_band_phase(width_plan[i]);
    end
    while (words_sent < WORD_BUDGET) begin
      run_band_phase(random_width());
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
